// ===== design/imu_frame_decode_heater_pi_core_macros.svh =====
// ----------------------------------------------------------------------------
// imu_frame_decode_heater_pi_core_macros.svh
// Assertion macros shared by the sensor frame decoder files.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_DECODE_HEATER_PI_CORE_MACROS_SVH
`define IMU_FRAME_DECODE_HEATER_PI_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define IMU_FDH_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IMU_FDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/imu_fdh_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_fdh_pkg
// Types and constants for the sensor frame decoder with PI heater loop.
// ----------------------------------------------------------------------------
package imu_fdh_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] HDR_GYRO  = 8'h82;
    localparam logic [7:0] HDR_ACCEL = 8'h92;
    localparam logic [7:0] HDR_TEMP  = 8'hA2;

    localparam int TARGET_W     = 10;
    localparam int GAIN_W       = 16;
    localparam int AXIS_W       = 20;
    localparam int TEMP_W       = 12;
    localparam int DUTY_W       = 10;
    localparam int ERR_W        = 13;
    localparam int INTEG_W      = 40;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 10'd320;
    localparam int TEMP_OFFSET = 184;     // 23 C in Q3
    localparam int ERR_WINDOW  = 4000;    // 500 C in Q3
    localparam int STABLE_ERR  = 8;       // 1 C in Q3
    localparam int DUTY_SHIFT  = 11;
    localparam int DUTY_MAX    = 1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_TARGET,
        REG_P_GAIN,
        REG_I_GAIN
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_GYRO,
        KIND_ACCEL,
        KIND_TEMP
    } t_kind;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] rx_b1;
        logic [7:0] rx_b2;
        logic [7:0] rx_b3;
        logic [7:0] rx_b4;
        logic [7:0] rx_b5;
        logic [7:0] rx_b6;
        logic [7:0] rx_b7;
    } t_in_word;

    typedef struct packed {
        t_kind                     kind;
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic signed [TEMP_W-1:0]  temperature;
        logic [DUTY_W-1:0]         heater_duty;
        logic                      stable;
    } t_out_word;

    typedef struct packed {
        logic                 enable;
        logic [TARGET_W-1:0]  target_temp;
        logic [GAIN_W-1:0]    p_gain;
        logic [GAIN_W-1:0]    i_gain;
    } t_cfg;

    typedef struct packed {
        logic temp_frame;   // word in the input register is a temperature frame
        logic commit;       // that word advances now and updates loop state
    } t_pi_ctl;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [DUTY_W-1:0]        duty;
        logic                     stable;
    } t_pi_res;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axes;

endpackage

// ===== design/imu_frame_decode_heater_pi_core.sv =====
// ----------------------------------------------------------------------------
// imu_frame_decode_heater_pi_core
// Sensor frame decoder: gyro and accel scaling, temperature decode and PI
// heater control.
// ----------------------------------------------------------------------------
// Takes one word per cycle when the result side keeps up. A word sits in the
// input register while the decode and the whole PI update (both gain
// products, saturating integrator add, duty clamp) settle; its result is then
// registered in the output register. The integrator update closes the loop
// between consecutive temperature words, so they may follow each other every
// cycle when the result side keeps up. Words are dropped without a result
// while enable is clear or the header is unknown.
// Config writes take effect on the next cycle and should be made while idle.
// ----------------------------------------------------------------------------
`include "imu_frame_decode_heater_pi_core_macros.svh"

module imu_frame_decode_heater_pi_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imu_fdh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imu_fdh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  imu_fdh_pkg::t_in_word                i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output imu_fdh_pkg::t_out_word               o_out_data
);
    import imu_fdh_pkg::*;

    t_cfg      cfg;
    t_pi_ctl   pi_ctl;
    t_pi_res   pi_res;
    t_axes     axes;

    logic      r_in_vld;
    logic      n_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    logic      n_out_vld;
    t_out_word r_out;
    t_out_word n_out;

    logic      s1_adv;
    logic      s1_gyro;
    logic      s1_accel;
    logic      s1_temp;
    logic      s1_emit;

    imu_fdh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign s1_gyro  = (r_in.header == HDR_GYRO);
    assign s1_accel = (r_in.header == HDR_ACCEL);
    assign s1_temp  = (r_in.header == HDR_TEMP);
    assign s1_emit  = cfg.enable && (s1_gyro || s1_accel || s1_temp);
    assign s1_adv   = r_in_vld && (!r_out_vld || i_out_ready);

    assign o_in_ready = !r_in_vld || s1_adv;

    assign pi_ctl.temp_frame = s1_temp;
    assign pi_ctl.commit     = s1_adv && cfg.enable && s1_temp;

    imu_fdh_axis u_axis (
        .i_word  (r_in),
        .i_accel (s1_accel),
        .o_axes  (axes)
    );

    imu_fdh_pi u_pi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctl   (pi_ctl),
        .i_b2    (r_in.rx_b2),
        .i_b3    (r_in.rx_b3),
        .o_res   (pi_res)
    );

    always_comb begin
        n_out        = '0;
        n_out.stable = pi_res.stable;
        if (s1_temp) begin
            n_out.kind        = KIND_TEMP;
            n_out.temperature = pi_res.temperature;
            n_out.heater_duty = pi_res.duty;
        end else begin
            n_out.kind   = s1_accel ? KIND_ACCEL : KIND_GYRO;
            n_out.axis_x = axes.x;
            n_out.axis_y = axes.y;
            n_out.axis_z = axes.z;
        end
    end

    always_comb begin
        n_in_vld = r_in_vld;
        if (o_in_ready) begin
            n_in_vld = i_in_valid;
        end
        n_out_vld = r_out_vld;
        if (s1_adv) begin
            n_out_vld = s1_emit;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (s1_adv && s1_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `IMU_FDH_ASSERT(a_duty_max, o_out_valid,
        32'(o_out_data.heater_duty) <= DUTY_MAX, "heater duty above limit")
    `IMU_FDH_ASSERT(a_temp_axes_zero, o_out_valid && (o_out_data.kind == KIND_TEMP),
        (o_out_data.axis_x == '0) && (o_out_data.axis_y == '0) && (o_out_data.axis_z == '0),
        "axis fields set on temperature word")
    `IMU_FDH_ASSERT(a_motion_pi_zero, o_out_valid && (o_out_data.kind != KIND_TEMP),
        (o_out_data.temperature == '0) && (o_out_data.heater_duty == '0),
        "heater fields set on motion word")
    `IMU_FDH_ASSERT_NEXT(a_drop_no_result, s1_adv && !s1_emit, !o_out_valid,
        "result shown for a dropped word")

endmodule

// ===== design/imu_fdh_cfg.sv =====
// ----------------------------------------------------------------------------
// imu_fdh_cfg
// Configuration register file: enable, heater target and PI gains.
// ----------------------------------------------------------------------------
module imu_fdh_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imu_fdh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imu_fdh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output imu_fdh_pkg::t_cfg                    o_cfg
);
    import imu_fdh_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE: n_cfg.enable      = i_cfg_data[0];
                REG_TARGET: n_cfg.target_temp = i_cfg_data[TARGET_W-1:0];
                REG_P_GAIN: n_cfg.p_gain      = i_cfg_data[GAIN_W-1:0];
                REG_I_GAIN: n_cfg.i_gain      = i_cfg_data[GAIN_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b0;
            r_cfg.target_temp <= TARGET_RESET;
            r_cfg.p_gain      <= '0;
            r_cfg.i_gain      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/imu_fdh_axis.sv =====
// ----------------------------------------------------------------------------
// imu_fdh_axis
// Three-axis scaling for gyro and accel frames.
// ----------------------------------------------------------------------------
module imu_fdh_axis (
    input  imu_fdh_pkg::t_in_word  i_word,
    input  logic                   i_accel,
    output imu_fdh_pkg::t_axes     o_axes
);
    import imu_fdh_pkg::*;

    // gyro: floor(raw * 125 / 8), fits 20 bits after the shift
    function automatic logic signed [AXIS_W-1:0] gyro_scale(input logic [7:0] hi,
                                                           input logic [7:0] lo);
        logic signed [15:0] raw;
        logic signed [22:0] prod;
        raw  = $signed({hi, lo});
        prod = 23'(raw) * 23'sd125;
        return prod[22:3];
    endfunction

    function automatic logic signed [AXIS_W-1:0] accel_scale(input logic [7:0] hi,
                                                            input logic [7:0] lo);
        logic signed [15:0] raw;
        raw = $signed({hi, lo});
        return AXIS_W'(raw) * 20'sd12;
    endfunction

    always_comb begin
        if (i_accel) begin
            o_axes.x = accel_scale(i_word.rx_b3, i_word.rx_b2);
            o_axes.y = accel_scale(i_word.rx_b5, i_word.rx_b4);
            o_axes.z = accel_scale(i_word.rx_b7, i_word.rx_b6);
        end else begin
            o_axes.x = gyro_scale(i_word.rx_b2, i_word.rx_b1);
            o_axes.y = gyro_scale(i_word.rx_b4, i_word.rx_b3);
            o_axes.z = gyro_scale(i_word.rx_b6, i_word.rx_b5);
        end
    end

endmodule

// ===== design/imu_fdh_pi.sv =====
// ----------------------------------------------------------------------------
// imu_fdh_pi
// Temperature decode and PI heater loop with saturating integrator and
// sticky stable flag.
// ----------------------------------------------------------------------------
`include "imu_frame_decode_heater_pi_core_macros.svh"

module imu_fdh_pi (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imu_fdh_pkg::t_cfg     i_cfg,
    input  imu_fdh_pkg::t_pi_ctl  i_ctl,
    input  logic [7:0]            i_b2,
    input  logic [7:0]            i_b3,
    output imu_fdh_pkg::t_pi_res  o_res
);
    import imu_fdh_pkg::*;

    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int SUM_W  = INTEG_W + 1;
    localparam int DQ_W   = SUM_W - DUTY_SHIFT;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [INTEG_W-1:0] n_integ;
    logic                      r_stable;
    logic                      n_stable;

    logic signed [10:0]        raw;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [ERR_W-1:0]   err;
    logic                      in_window;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [SUM_W-1:0]   acc;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DQ_W-1:0]    duty_q;
    logic signed [DQ_W-1:0]    duty_c;
    logic                      stable_new;

    always_comb begin
        raw       = $signed({i_b2, i_b3[7:5]});
        temp      = TEMP_W'(raw) + TEMP_W'(TEMP_OFFSET);
        err       = $signed({3'b000, i_cfg.target_temp}) - ERR_W'(temp);
        in_window = (32'(err) < ERR_WINDOW) && (32'(err) > -ERR_WINDOW);

        prod_i = PROD_W'(err) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_cfg.i_gain});
        prod_p = PROD_W'(err) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_cfg.p_gain});

        // integrator add with saturation to 40 bits
        acc = SUM_W'(r_integ) + (in_window ? SUM_W'(prod_i) : SUM_W'(0));
        if (acc[SUM_W-1] != acc[SUM_W-2]) begin
            integ_new = acc[SUM_W-1] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_new = acc[INTEG_W-1:0];
        end

        // floor divide by 2048, then clamp
        sum    = SUM_W'(prod_p) + SUM_W'(integ_new);
        duty_q = sum[SUM_W-1:DUTY_SHIFT];
        if (duty_q < 0) begin
            duty_c = '0;
        end else if (32'(duty_q) > DUTY_MAX) begin
            duty_c = DQ_W'(DUTY_MAX);
        end else begin
            duty_c = duty_q;
        end

        stable_new = r_stable || (32'(err) < STABLE_ERR);
    end

    always_comb begin
        n_integ  = i_ctl.commit ? integ_new : r_integ;
        n_stable = i_ctl.commit ? stable_new : r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= '0;
            r_stable <= 1'b0;
        end else begin
            r_integ  <= n_integ;
            r_stable <= n_stable;
        end
    end

    assign o_res.temperature = temp;
    assign o_res.duty        = duty_c[DUTY_W-1:0];
    assign o_res.stable      = i_ctl.temp_frame ? stable_new : r_stable;

    `IMU_FDH_ASSERT_NEXT(a_stable_sticky, r_stable, r_stable, "stable flag cleared")
    `IMU_FDH_ASSERT_NEXT(a_integ_hold, i_rst_n && !i_ctl.commit, $stable(r_integ),
        "integrator moved without a committed temperature word")

endmodule

// ===== tb/tb_imu_frame_decode_heater_pi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_frame_decode_heater_pi_core
// Self-checking bench for the sensor frame decoder and PI heater loop. Frames
// are pushed through a valid/ready input with random gaps, results are drained
// with random back-pressure and compared field by field against an in-bench
// model of the scaling, temperature decode, integrator and stable flag.
// Registers are reprogrammed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_imu_frame_decode_heater_pi_core;
    import imu_fdh_pkg::*;

    localparam longint INTEG_HI = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO = -(64'sd1 <<< (INTEG_W - 1));

    // expected decode of every accepted word that yields a result, plus the loop state behind it
    class decode_book;
        t_cfg        regs;
        longint      integ;
        bit          stable_seen;
        t_out_word   decoded_due[$];
        int unsigned mismatches;

        function new();
            regs.enable      = 1'b0;
            regs.target_temp = TARGET_RESET;
            regs.p_gain      = '0;
            regs.i_gain      = '0;
            integ            = 0;
            stable_seen      = 1'b0;
            mismatches       = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE: regs.enable      = data[0];
                REG_TARGET: regs.target_temp = data[TARGET_W-1:0];
                REG_P_GAIN: regs.p_gain      = data[GAIN_W-1:0];
                REG_I_GAIN: regs.i_gain      = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_accepted(t_in_word w);
            t_out_word          r;
            logic signed [15:0] wx, wy, wz;
            logic signed [10:0] raw;
            int                 temp, err;
            longint             duty;
            if (!regs.enable) return;
            r = '0;
            case (w.header)
                HDR_GYRO: begin
                    wx = {w.rx_b2, w.rx_b1};
                    wy = {w.rx_b4, w.rx_b3};
                    wz = {w.rx_b6, w.rx_b5};
                    r.kind   = KIND_GYRO;
                    r.axis_x = AXIS_W'((int'(wx) * 125) >>> 3);
                    r.axis_y = AXIS_W'((int'(wy) * 125) >>> 3);
                    r.axis_z = AXIS_W'((int'(wz) * 125) >>> 3);
                end
                HDR_ACCEL: begin
                    wx = {w.rx_b3, w.rx_b2};
                    wy = {w.rx_b5, w.rx_b4};
                    wz = {w.rx_b7, w.rx_b6};
                    r.kind   = KIND_ACCEL;
                    r.axis_x = AXIS_W'(int'(wx) * 12);
                    r.axis_y = AXIS_W'(int'(wy) * 12);
                    r.axis_z = AXIS_W'(int'(wz) * 12);
                end
                HDR_TEMP: begin
                    raw  = {w.rx_b2, w.rx_b3[7:5]};
                    temp = int'(raw) + TEMP_OFFSET;
                    err  = int'(regs.target_temp) - temp;
                    if (err < ERR_WINDOW && err > -ERR_WINDOW) begin
                        integ = integ + longint'(err) * longint'(regs.i_gain);
                        if (integ > INTEG_HI)
                            integ = INTEG_HI;
                        else if (integ < INTEG_LO)
                            integ = INTEG_LO;
                    end
                    // >>> on a signed longint floors, as the hardware shift does
                    duty = (longint'(err) * longint'(regs.p_gain) + integ) >>> DUTY_SHIFT;
                    if (duty < 0)
                        duty = 0;
                    else if (duty > DUTY_MAX)
                        duty = DUTY_MAX;
                    if (err < STABLE_ERR)
                        stable_seen = 1'b1;
                    r.kind        = KIND_TEMP;
                    r.temperature = temp[TEMP_W-1:0];
                    r.heater_duty = duty[DUTY_W-1:0];
                end
                default: return;
            endcase
            r.stable = stable_seen;
            decoded_due.push_back(r);
        endfunction

        function void match_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_decoded(t_out_word got);
            t_out_word want;
            if (decoded_due.size() == 0) begin
                $error("result word with none expected, kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = decoded_due.pop_front();
            match_field("kind", want.kind, got.kind);
            match_field("axis_x", want.axis_x, got.axis_x);
            match_field("axis_y", want.axis_y, got.axis_y);
            match_field("axis_z", want.axis_z, got.axis_z);
            match_field("temperature", want.temperature, got.temperature);
            match_field("heater_duty", want.heater_duty, got.heater_duty);
            match_field("stable", want.stable, got.stable);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_word               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_word              o_out_data;

    decode_book book = new();
    bit         jitter_on;

    imu_frame_decode_heater_pi_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_in_word axes_frame(logic [7:0] hdr, logic [15:0] x,
                                            logic [15:0] y, logic [15:0] z);
        t_in_word w;
        w = {$urandom, $urandom};
        w.header = hdr;
        if (hdr == HDR_GYRO) begin
            {w.rx_b2, w.rx_b1} = x;
            {w.rx_b4, w.rx_b3} = y;
            {w.rx_b6, w.rx_b5} = z;
        end else begin
            {w.rx_b3, w.rx_b2} = x;
            {w.rx_b5, w.rx_b4} = y;
            {w.rx_b7, w.rx_b6} = z;
        end
        return w;
    endfunction

    // 11-bit code lands in b2 and the top of b3; the rest of b3 is don't-care
    function automatic t_in_word temp_frame(int raw);
        t_in_word w;
        w = {$urandom, $urandom};
        w.header     = HDR_TEMP;
        w.rx_b2      = raw[10:3];
        w.rx_b3[7:5] = raw[2:0];
        return w;
    endfunction

    function automatic t_in_word random_frame();
        t_in_word w;
        int       pick, raw;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            w = axes_frame(HDR_GYRO, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 56) begin
            w = axes_frame(HDR_ACCEL, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 72) begin
            w = temp_frame(int'($urandom_range(0, 2047)) - 1024);
        end else if (pick < 88) begin
            // close to the setpoint so the duty lands inside its range
            raw = int'(book.regs.target_temp) - TEMP_OFFSET
                + int'($urandom_range(0, 64)) - 32;
            if (raw > 1023) raw = 1023;
            if (raw < -1024) raw = -1024;
            w = temp_frame(raw);
        end else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = jitter_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        book.note_accepted(w);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int count);
        for (int n = 0; n < count; n++)
            send_word(random_frame());
        i_in_valid = 1'b0;
    endtask

    // wait out every pending result, then the two-stage pipe for dropped words
    task automatic settle();
        while (book.decoded_due.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // junk in the unused upper bits checks that the core masks them
    task automatic program_regs(input logic en, input logic [TARGET_W-1:0] target,
                                input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [31:0]           noise;
        noise            = $urandom;
        vals[REG_ENABLE] = {noise[15:1], en};
        vals[REG_TARGET] = {noise[31:26], target};
        vals[REG_P_GAIN] = kp;
        vals[REG_I_GAIN] = ki;
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = t_reg_idx'(k);
            i_cfg_data = vals[k];
            book.write_reg(t_reg_idx'(k), vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
    endtask

    // result side: random back-pressure per word
    initial begin
        int stall;
        forever begin
            stall = jitter_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            book.check_decoded(o_out_data);
            @(negedge i_clk);
        end
    end

    initial begin
        t_in_word plan[$];
        t_in_word w;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_ENABLE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        jitter_on  = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // enable is clear out of reset: these words must vanish
        send_word(axes_frame(HDR_GYRO, 16'h1234, 16'h8000, 16'h7FFF));
        send_word(temp_frame(0));
        send_word(axes_frame(HDR_ACCEL, 16'hFFFF, 16'h0001, 16'h8000));
        i_in_valid = 1'b0;
        settle();

        // target 800, duty equals the error in Q3 counts
        program_regs(1'b1, 10'd800, 16'd2048, 16'd0);
        plan.push_back(axes_frame(HDR_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF));
        plan.push_back(axes_frame(HDR_GYRO, 16'h0000, 16'h0001, 16'h8001));
        plan.push_back(axes_frame(HDR_ACCEL, 16'h7FFF, 16'h8000, 16'hFFFF));
        plan.push_back(axes_frame(HDR_ACCEL, 16'h0000, 16'h0001, 16'h8001));
        plan.push_back(temp_frame(-1024));      // coldest code, duty clamps high
        plan.push_back(temp_frame(0));
        plan.push_back(temp_frame(608));        // error of exactly one degree
        w = {$urandom, $urandom}; w.header = 8'h00; plan.push_back(w);
        w = {$urandom, $urandom}; w.header = 8'hFF; plan.push_back(w);
        w = {$urandom, $urandom}; w.header = 8'h83; plan.push_back(w);
        w = {$urandom, $urandom}; w.header = 8'hA3; plan.push_back(w);
        plan.push_back(temp_frame(609));        // just under a degree: goes stable
        plan.push_back(temp_frame(1023));       // hottest code, duty clamps at zero
        w = '1; w.header = HDR_TEMP; plan.push_back(w);
        plan.push_back(axes_frame(HDR_GYRO, 16'($urandom), 16'($urandom), 16'($urandom)));
        plan.push_back(axes_frame(HDR_ACCEL, 16'h0000, 16'h0000, 16'h0000));
        foreach (plan[k])
            send_word(plan[k]);
        i_in_valid = 1'b0;
        settle();

        program_regs(1'b1, 10'd0, 16'hFFFF, 16'd0);
        run_phase(150);
        settle();
        jitter_on = 1'b0;
        program_regs(1'b1, 10'd1023, 16'd3000, 16'd1);
        run_phase(150);
        settle();
        jitter_on = 1'b1;
        program_regs(1'b1, TARGET_RESET, 16'd0, 16'd0);
        run_phase(100);
        settle();

        // disabled: nothing comes out and the loop state holds
        program_regs(1'b0, TARGET_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        run_phase(40);
        settle();

        for (int k = 0; k < 3; k++) begin
            jitter_on = k[0];
            program_regs(1'b1, TARGET_W'($urandom), GAIN_W'($urandom_range(0, 4095)),
                         GAIN_W'($urandom_range(0, 63)));
            run_phase(100);
            settle();
        end
        jitter_on = 1'b1;
        program_regs(1'b1, TARGET_W'($urandom), GAIN_W'($urandom),
                     GAIN_W'($urandom_range(0, 255)));
        run_phase(150);
        settle();
        program_regs(1'b1, TARGET_W'($urandom), 16'hFFFF, 16'hFFFF);
        run_phase(150);
        settle();
        program_regs(1'b1, TARGET_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        run_phase(150);
        settle();

        // back-to-back cold words drive the integrator hard upward
        jitter_on = 1'b0;
        program_regs(1'b1, 10'd1023, 16'd0, 16'hFFFF);
        repeat (60) send_word(temp_frame(-1024));
        i_in_valid = 1'b0;
        settle();

        if (book.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/imu_fdh_pkg.sv
design/imu_fdh_cfg.sv
design/imu_fdh_axis.sv
design/imu_fdh_pi.sv
design/imu_frame_decode_heater_pi_core.sv
tb/tb_imu_frame_decode_heater_pi_core.sv
